// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Each use names a label, the clock, the property and a message; SKT_ASSERT_RST also takes the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define SKT_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define SKT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/skt_pkg.sv =====
// Shared types, constants and character-class functions of the schema tokenizer.
// No dependencies; used by the lexer core, the result queue and the top level.
`timescale 1ns / 1ps

package skt_pkg;

    // Default widths of the internal counters
    localparam int POSITION_BITS_DEF = 16;
    localparam int LINE_BITS_DEF     = 16;

    // Width of offsets, lengths and lines in the results
    localparam int OUT_BITS = 16;

    // Result queue
    localparam int FIFO_DEPTH = 4;

    // Reserved words
    localparam int KW_COUNT    = 6;
    localparam int KW_MAX_LEN  = 9;
    localparam int KW_IDX_BITS = $clog2(KW_MAX_LEN);

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00, 8'h00},
        '{"u", "n", "i", "o", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "a", "m", "e", "s", "p", "a", "c", "e"}
    };
    localparam logic [KW_IDX_BITS:0] KW_LEN [KW_COUNT] = '{
        (KW_IDX_BITS+1)'(6), (KW_IDX_BITS+1)'(5), (KW_IDX_BITS+1)'(4),
        (KW_IDX_BITS+1)'(2), (KW_IDX_BITS+1)'(3), (KW_IDX_BITS+1)'(9)
    };

    // Token kinds
    typedef enum logic [4:0] {
        KIND_STRUCT    = 5'd0,
        KIND_UNION     = 5'd1,
        KIND_CASE      = 5'd2,
        KIND_AS        = 5'd3,
        KIND_USE       = 5'd4,
        KIND_NAMESPACE = 5'd5,
        KIND_BANG      = 5'd6,
        KIND_QUESTION  = 5'd7,
        KIND_STAR      = 5'd8,
        KIND_PLUS      = 5'd9,
        KIND_COLON     = 5'd10,
        KIND_BARE      = 5'd11,
        KIND_LBRACE    = 5'd12,
        KIND_RBRACE    = 5'd13,
        KIND_DOT       = 5'd14,
        KIND_SEMI      = 5'd15,
        KIND_END       = 5'd16,
        KIND_ERROR     = 5'd17
    } t_kind;

    // Special characters
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // One result
    typedef struct packed {
        t_kind                kind;
        logic [OUT_BITS-1:0]  start;
        logic [OUT_BITS-1:0]  length;
        logic [OUT_BITS-1:0]  line;
        logic [7:0]           bad;
        logic                 last;
    } t_token;

    // Results produced by one text byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic is_word_start(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_word_cont(input logic [7:0] c);
        return is_word_start(c) || (c inside {["0":"9"]});
    endfunction

    // Single-character marks; anything else maps to the error kind
    function automatic t_kind mark_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            "!":     k = KIND_BANG;
            "?":     k = KIND_QUESTION;
            "*":     k = KIND_STAR;
            "+":     k = KIND_PLUS;
            ":":     k = KIND_COLON;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ".":     k = KIND_DOT;
            ";":     k = KIND_SEMI;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/schema_keyword_tokenizer.sv =====
// A token passes through the input register, then the result queue, before it is
// offered. Throughput: one byte per cycle while the queue has room, limited by the single
// output beat per cycle: a byte that ends a word and is a mark itself gives two tokens.
// Input is taken whenever the input register is free or the queue has room for two.
// Reset: synchronous, active low; clears the queue and returns to the start of a text.
// Depends on skt_pkg, skt_lexer_core, skt_result_fifo and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module schema_keyword_tokenizer #(
    parameter int POSITION_BITS = skt_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = skt_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // text request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    // token request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length,
                                        // [47:32] line_number, [55:48] bad_byte
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // run_last
);

    localparam int CNT_BITS = $clog2(skt_pkg::FIFO_DEPTH) + 1;

    skt_pkg::t_push        push;
    skt_pkg::t_token       out_tok;
    logic [CNT_BITS-1:0]   fifo_count;
    logic                  room;

    // Room for the largest result set of one byte
    assign room = (fifo_count <= CNT_BITS'(skt_pkg::FIFO_DEPTH - 2));

    skt_lexer_core #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_eot   (s_axis_tlast),
        .i_room  (room),
        .o_push  (push)
    );

    skt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_token (out_tok),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {out_tok.bad, out_tok.line, out_tok.length, out_tok.start};
    assign m_axis_tuser = out_tok.kind;
    assign m_axis_tlast = out_tok.last;

    // Queue never holds more than its depth
    `SKT_ASSERT_ALWAYS(a_fifo_bound, i_clk, !i_rst_n || (fifo_count <= CNT_BITS'(skt_pkg::FIFO_DEPTH)), "queue overfilled")

    // A push always fits in what is free
    `SKT_ASSERT_RST(a_push_fits, i_clk, i_rst_n, (push.count == 2'd0) || ((32'(fifo_count) + 32'(push.count)) <= 32'(skt_pkg::FIFO_DEPTH)), "push without room")

    // Only the last token of a byte carries the run end flag
    `SKT_ASSERT_RST(a_two_last, i_clk, i_rst_n, (push.count != 2'd2) || (!push.tok0.last && push.tok1.last), "run end flag on wrong token")

    `SKT_ASSERT_RST(a_one_last, i_clk, i_rst_n, (push.count != 2'd1) || push.tok0.last, "single token without run end flag")

endmodule

// ===== hw/rtl/skt_result_fifo.sv =====
// Small result queue of the tokenizer: takes up to two tokens a cycle, gives one.
// Depends on skt_pkg for the token types and depth.
`timescale 1ns / 1ps

module skt_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skt_pkg::t_push       i_push,
    output logic                 o_valid,
    input  logic                 i_ready,
    output skt_pkg::t_token      o_token,
    output logic [$clog2(skt_pkg::FIFO_DEPTH):0] o_count
);

    localparam int PTR_BITS = $clog2(skt_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    skt_pkg::t_token       r_mem [skt_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [PTR_BITS-1:0]   wr_ptr_1;
    logic                  pop;

    assign o_valid  = (r_count != '0);
    assign o_token  = r_mem[r_rd_ptr];
    assign o_count  = r_count;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + PTR_BITS'(1);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_BITS'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count + CNT_BITS'(i_push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; first token at the write pointer, second just after it
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.tok1;
        end
    end

endmodule

// ===== hw/rtl/skt_lexer_core.sv =====
// Lexer core: input register, word and line state, and token formation.
// Depends on skt_pkg for kinds, keyword tables and character classes.
`timescale 1ns / 1ps

module skt_lexer_core #(
    parameter int POSITION_BITS = skt_pkg::POSITION_BITS_DEF,
    parameter int LINE_BITS     = skt_pkg::LINE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_byte,
    input  logic            i_eot,
    input  logic            i_room,
    output skt_pkg::t_push  o_push
);

    localparam int OB = skt_pkg::OUT_BITS;
    localparam int PW = (POSITION_BITS > OB) ? POSITION_BITS : OB;
    localparam int LW = (LINE_BITS > OB) ? LINE_BITS : OB;
    localparam int KC = skt_pkg::KW_COUNT;
    localparam int KI = skt_pkg::KW_IDX_BITS;

    // Input register
    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      r_in_eot;

    // Lexer state
    logic                      r_in_word,  n_in_word;
    logic [POSITION_BITS-1:0]  r_wstart,   n_wstart;
    logic [POSITION_BITS-1:0]  r_wlen,     n_wlen;
    logic [KC-1:0]             r_alive,    n_alive;
    logic [POSITION_BITS-1:0]  r_pos,      n_pos;
    logic [LINE_BITS-1:0]      r_line,     n_line;
    logic                      r_failed,   n_failed;

    logic                      advance;
    logic                      flush;
    logic                      own;
    skt_pkg::t_token           word_tok;
    skt_pkg::t_token           own_tok;
    skt_pkg::t_kind            mk;
    logic [POSITION_BITS-1:0]  pos_inc;
    logic [POSITION_BITS-1:0]  wlen_inc;

    function automatic logic [OB-1:0] clip_pos(input logic [POSITION_BITS-1:0] v);
        logic [PW-1:0] ext;
        ext = PW'(v);
        return (ext > PW'({OB{1'b1}})) ? {OB{1'b1}} : ext[OB-1:0];
    endfunction

    function automatic logic [OB-1:0] clip_line(input logic [LINE_BITS-1:0] v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        return (ext > LW'({OB{1'b1}})) ? {OB{1'b1}} : ext[OB-1:0];
    endfunction

    // Keep the reserved words that still match after character c at place idx
    function automatic logic [KC-1:0] advance_alive(input logic [KC-1:0] alive,
                                                    input logic [POSITION_BITS-1:0] idx,
                                                    input logic [7:0] c);
        logic [KC-1:0] res;
        res = '0;
        for (int k = 0; k < KC; k++) begin
            if (alive[k] && (idx < POSITION_BITS'(skt_pkg::KW_LEN[k])) &&
                (skt_pkg::KW_TEXT[k][idx[KI-1:0]] == c)) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

    assign advance  = r_in_valid && i_room;
    assign o_ready  = !r_in_valid || advance;
    assign pos_inc  = (r_pos == '1) ? r_pos : r_pos + POSITION_BITS'(1);
    assign wlen_inc = (r_wlen == '1) ? r_wlen : r_wlen + POSITION_BITS'(1);
    assign mk       = skt_pkg::mark_kind(r_in_byte);

    // Word token: reserved word on exact length, bare word otherwise
    always_comb begin
        word_tok        = '0;
        word_tok.kind   = skt_pkg::KIND_BARE;
        for (int k = 0; k < KC; k++) begin
            if (r_alive[k] && (r_wlen == POSITION_BITS'(skt_pkg::KW_LEN[k]))) begin
                word_tok.kind = skt_pkg::t_kind'(k);
            end
        end
        word_tok.start  = clip_pos(r_wstart);
        word_tok.length = clip_pos(r_wlen);
        word_tok.line   = clip_line(r_line);
        word_tok.bad    = 8'h00;
        word_tok.last   = 1'b0;
    end

    // Token of the byte itself: end marker, mark or error
    always_comb begin
        own_tok       = '0;
        own_tok.start = clip_pos(r_pos);
        own_tok.line  = clip_line(r_line);
        own_tok.last  = 1'b1;
        if (r_in_eot) begin
            own_tok.kind   = skt_pkg::KIND_END;
            own_tok.length = '0;
            own_tok.bad    = 8'h00;
        end else begin
            own_tok.kind   = mk;
            own_tok.length = OB'(1);
            own_tok.bad    = (mk == skt_pkg::KIND_ERROR) ? r_in_byte : 8'h00;
        end
    end

    // Which results this byte gives
    always_comb begin
        flush = !r_failed && r_in_word &&
                (r_in_eot || !skt_pkg::is_word_cont(r_in_byte));
        own   = !r_failed &&
                (r_in_eot || (!skt_pkg::is_word_start(r_in_byte) &&
                              !(r_in_word && skt_pkg::is_word_cont(r_in_byte)) &&
                              r_in_byte != skt_pkg::CHAR_SPACE &&
                              r_in_byte != skt_pkg::CHAR_TAB &&
                              r_in_byte != skt_pkg::CHAR_NEWLINE));
        o_push = '0;
        if (advance) begin
            o_push.count = 2'(flush) + 2'(own);
            if (flush) begin
                o_push.tok0      = word_tok;
                o_push.tok0.last = !own;
                o_push.tok1      = own_tok;
            end else begin
                o_push.tok0      = own_tok;
            end
        end
    end

    // Next state
    always_comb begin
        n_in_word = r_in_word;
        n_wstart  = r_wstart;
        n_wlen    = r_wlen;
        n_alive   = r_alive;
        n_pos     = r_pos;
        n_line    = r_line;
        n_failed  = r_failed;
        if (r_in_eot) begin
            // back to the start of a new text
            n_in_word = 1'b0;
            n_wstart  = '0;
            n_wlen    = '0;
            n_alive   = '1;
            n_pos     = '0;
            n_line    = LINE_BITS'(1);
            n_failed  = 1'b0;
        end else if (!r_failed) begin
            if (r_in_word && skt_pkg::is_word_cont(r_in_byte)) begin
                n_alive = advance_alive(r_alive, r_wlen, r_in_byte);
                n_wlen  = wlen_inc;
            end else begin
                n_in_word = 1'b0;
                if (skt_pkg::is_word_start(r_in_byte)) begin
                    n_in_word = 1'b1;
                    n_wstart  = r_pos;
                    n_wlen    = POSITION_BITS'(1);
                    n_alive   = advance_alive('1, '0, r_in_byte);
                end else if (r_in_byte == skt_pkg::CHAR_NEWLINE) begin
                    n_line = (r_line == '1) ? r_line : r_line + LINE_BITS'(1);
                end else if (mk == skt_pkg::KIND_ERROR &&
                             r_in_byte != skt_pkg::CHAR_SPACE &&
                             r_in_byte != skt_pkg::CHAR_TAB) begin
                    n_failed = 1'b1;
                end
            end
            n_pos = pos_inc;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_eot  <= i_eot;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_wstart  <= '0;
            r_wlen    <= '0;
            r_alive   <= '1;
            r_pos     <= '0;
            r_line    <= LINE_BITS'(1);
            r_failed  <= 1'b0;
        end else if (advance) begin
            r_in_word <= n_in_word;
            r_wstart  <= n_wstart;
            r_wlen    <= n_wlen;
            r_alive   <= n_alive;
            r_pos     <= n_pos;
            r_line    <= n_line;
            r_failed  <= n_failed;
        end
    end

endmodule
